FILE: design/gthin_pkg.sv
// Shared types and constants for the gradient edge thinning block.
package gthin_pkg;

  localparam int MaxHalfWidth = 8;
  localparam int DiagNum      = 11583;

  localparam logic [1:0] AXIS_VERT  = 2'd0;
  localparam logic [1:0] AXIS_HORZ  = 2'd1;
  localparam logic [1:0] AXIS_DIAG  = 2'd2;
  localparam logic [1:0] AXIS_ANTI  = 2'd3;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF_WIDTH   = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [1:0] axis;
    logic       grad_zero;
  } gthin_axis_t;

endpackage

FILE: design/gthin_axis.sv
// Gradient projection unit: registers the four axis magnitudes and picks the dominant axis.
module gthin_axis (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic signed [15:0]        grad_x_i,
  input  logic signed [15:0]        grad_y_i,
  output gthin_pkg::gthin_axis_t    axis_o
);
  import gthin_pkg::*;

  logic signed [16:0] sx, sy, ssum, sdif;
  logic [15:0]        ax, ay;
  logic [16:0]        asum, adif;
  logic [30:0]        asum_w, adif_w;
  logic [30:0]        pn_d, pe_d, pne_d, pnw_d;
  logic [30:0]        pn_q, pe_q, pne_q, pnw_q;
  logic               gz_d, gz_q;

  always_comb begin
    sx     = 17'(grad_x_i);
    sy     = 17'(grad_y_i);
    ssum   = sx + sy;
    sdif   = sy - sx;
    ax     = sx[16] ? 16'(-sx) : 16'(sx);
    ay     = sy[16] ? 16'(-sy) : 16'(sy);
    asum   = ssum[16] ? 17'(-ssum) : 17'(ssum);
    adif   = sdif[16] ? 17'(-sdif) : 17'(sdif);
    asum_w = 31'(asum);
    adif_w = 31'(adif);
    pn_d   = {1'b0, ay, 14'd0};
    pe_d   = {1'b0, ax, 14'd0};
    pne_d  = asum_w * 31'(DiagNum);
    pnw_d  = adif_w * 31'(DiagNum);
    gz_d   = (grad_x_i == 16'sd0) && (grad_y_i == 16'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pn_q  <= pn_d;
      pe_q  <= pe_d;
      pne_q <= pne_d;
      pnw_q <= pnw_d;
      gz_q  <= gz_d;
    end
  end

  // ties resolve vertical, horizontal, diagonal, anti-diagonal
  always_comb begin
    if (pn_q >= pe_q && pn_q >= pne_q && pn_q >= pnw_q) begin
      axis_o.axis = AXIS_VERT;
    end else if (pe_q >= pne_q && pe_q >= pnw_q) begin
      axis_o.axis = AXIS_HORZ;
    end else if (pne_q >= pnw_q) begin
      axis_o.axis = AXIS_DIAG;
    end else begin
      axis_o.axis = AXIS_ANTI;
    end
    axis_o.grad_zero = gz_q;
  end

endmodule

FILE: design/gradient_edge_thinning.sv
// Gradient edge thinning: frame store with non-maximum suppression queries.
//
// Input stream: each beat is a load (tuser 0) or a query (tuser 1). A load
// writes pixel_value at (col, row) into the on-chip frame store in the cycle
// it is accepted and gives no result; the next beat may follow immediately.
// A query reads the center pixel and, along the dominant gradient axis,
// half_width (capped at 8) neighbors on each side, and returns one result
// beat: kept and the pixel value if a strict local maximum, zeros otherwise.
// Query steps: acceptance registers the gradient projections, ST_CALC the
// margin test and center read, ST_SEL the center pixel and axis; ST_SCAN
// reads one neighbor pair per cycle and stops early once the margin,
// gradient, center or a neighbor check fails; ST_DONE queues the result.
// One query is in work at a time; tready is low while it runs.
// The result sits in an output register; a new beat is accepted while it
// waits, and a finished query holds until the register frees up.
// Reset clears control state and sets frame 256 x 256, half_width 1; the
// frame store is not cleared and must be loaded before it is queried.
// Configuration writes are taken at any time (cfg_ready_o is always high)
// and are meant to happen only while the block is idle.
module gradient_edge_thinning #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // col[7:0], row[15:8], pixel_value[31:16], grad_x[47:32], grad_y[63:48]
  input  logic [63:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // thinned_value[15:0]
  output logic [15:0] m_axis_tdata,
  // kept[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [8:0]  cfg_data_i
);
  import gthin_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  function automatic logic [AddrW-1:0] addr_of(input logic [7:0] c, input logic [7:0] r);
    return AddrW'(r) * AddrW'(MAX_WIDTH) + AddrW'(c);
  endfunction

  logic [PIXEL_BITS-1:0] mem [Depth];
  logic [PIXEL_BITS-1:0] rd_a_q, rd_b_q;
  logic [AddrW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
  logic                  wr_en;

  logic [8:0] frame_width_q, frame_height_q;
  logic [3:0] half_width_q;
  logic [8:0] wid, hgt;
  logic [3:0] sc;

  logic [2:0] state_q, state_d;
  logic [7:0] cx_q, cy_q;
  logic       ok_q, ok_d;
  logic [1:0] axis_q, axis_d;
  logic [PIXEL_BITS-1:0] pix_q, pix_d;
  logic       fail_q, fail_d;
  logic       chk_q, chk_d;
  logic [4:0] step_q, step_d;
  logic       out_vld_q, out_vld_d;
  logic       out_kept_q, out_kept_d;
  logic [15:0] out_val_q, out_val_d;

  logic        in_acc;
  logic [7:0]  in_col, in_row;
  logic [15:0] in_pix;
  logic [7:0]  xp, xm, yp, ym;
  logic [7:0]  na_x, na_y, nb_x, nb_y;
  logic        margin;
  gthin_axis_t axis_info;

  assign in_col = s_axis_tdata[7:0];
  assign in_row = s_axis_tdata[15:8];
  assign in_pix = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_val_q;
  assign m_axis_tuser[0] = out_kept_q;

  gthin_axis u_axis (
    .clk_i    (clk_i),
    .load_i   (in_acc && s_axis_tuser[0] == CMD_QUERY),
    .grad_x_i (s_axis_tdata[47:32]),
    .grad_y_i (s_axis_tdata[63:48]),
    .axis_o   (axis_info)
  );

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 9'd256;
      frame_height_q <= 9'd256;
      half_width_q   <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        REG_HALF_WIDTH:   half_width_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign wid = (32'(frame_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : frame_width_q;
  assign hgt = (32'(frame_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : frame_height_q;
  assign sc  = (32'(half_width_q) > MaxHalfWidth) ? 4'(MaxHalfWidth) : half_width_q;

  // frame store
  assign wr_en   = in_acc && (s_axis_tuser[0] == CMD_LOAD)
                   && (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
  assign wr_addr = addr_of(in_col, in_row);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= PIXEL_BITS'(in_pix);
    end
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

  // neighbor coordinates; valid whenever the margin test passed
  always_comb begin
    xp = cx_q + 8'(step_q);
    xm = cx_q - 8'(step_q);
    yp = cy_q + 8'(step_q);
    ym = cy_q - 8'(step_q);
    case (axis_q)
      AXIS_VERT: begin na_x = cx_q; na_y = yp;   nb_x = cx_q; nb_y = ym;   end
      AXIS_HORZ: begin na_x = xp;   na_y = cy_q; nb_x = xm;   nb_y = cy_q; end
      AXIS_DIAG: begin na_x = xp;   na_y = yp;   nb_x = xm;   nb_y = ym;   end
      default:   begin na_x = xm;   na_y = yp;   nb_x = xp;   nb_y = ym;   end
    endcase
    if (state_q == ST_SCAN) begin
      rd_addr_a = addr_of(na_x, na_y);
    end else begin
      rd_addr_a = addr_of(cx_q, cy_q);
    end
    rd_addr_b = addr_of(nb_x, nb_y);
  end

  assign margin = ({2'd0, cx_q} > {6'd0, sc})
                  && ({2'd0, cx_q} + {6'd0, sc} + 10'd1 < {1'b0, wid})
                  && ({2'd0, cy_q} > {6'd0, sc})
                  && ({2'd0, cy_q} + {6'd0, sc} + 10'd1 < {1'b0, hgt});

  always_comb begin
    state_d    = state_q;
    ok_d       = ok_q;
    axis_d     = axis_q;
    pix_d      = pix_q;
    fail_d     = fail_q;
    chk_d      = 1'b0;
    step_d     = step_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_kept_d = out_kept_q;
    out_val_d  = out_val_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser[0] == CMD_QUERY) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        ok_d    = margin;
        state_d = ST_SEL;
      end
      ST_SEL: begin
        axis_d  = axis_info.axis;
        pix_d   = rd_a_q;
        fail_d  = !ok_q || axis_info.grad_zero || (rd_a_q == '0);
        step_d  = 5'd1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (chk_q && (rd_a_q >= pix_q || rd_b_q >= pix_q)) begin
          fail_d = 1'b1;
        end
        if (!fail_d && step_q <= {1'b0, sc}) begin
          chk_d  = 1'b1;
          step_d = step_q + 5'd1;
        end else if (!chk_q || fail_d) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_kept_d = !fail_q;
          out_val_d  = fail_q ? 16'd0 : 16'(pix_q);
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_q     <= chk_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q <= in_col;
      cy_q <= in_row;
    end
    ok_q       <= ok_d;
    axis_q     <= axis_d;
    pix_q      <= pix_d;
    fail_q     <= fail_d;
    step_q     <= step_d;
    out_kept_q <= out_kept_d;
    out_val_q  <= out_val_d;
  end

endmodule

FILE: test/gradient_edge_thinning_tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for gradient_edge_thinning, predicted in-bench.
module gradient_edge_thinning_tb;
  import gthin_pkg::*;

  localparam int FrameCap     = 256;
  localparam int AxisScale    = 16384;
  localparam int SettleCycles = 40;
  localparam int PhaseBeats   = 150;
  localparam int PhaseCount   = 8;
  localparam int CycleLimit   = 400000;
  localparam int DirCount     = 26;

  typedef struct packed {
    logic        kept;
    logic [15:0] value;
  } thin_res_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] pix;
    logic [15:0] gx;
    logic [15:0] gy;
    logic        typed;
    thin_res_t   res;
  } dir_row_t;

  localparam thin_res_t Rejected = '{1'b0, 16'd0};

  // directed rows at reset settings: 256 x 256 frame, half_width 1
  localparam dir_row_t DirRows [DirCount] = '{
    '{CMD_LOAD,  8'd10,  8'd10,  16'd1000,  16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd10,  8'd9,   16'd999,   16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd10,  8'd11,  16'd5,     16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'h0000, 16'h4000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd9,   8'd10,  16'd200,   16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd11,  8'd10,  16'd1000,  16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'hFFFF,  16'h4000, 16'h0000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd11,  8'd11,  16'd0,     16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd9,   8'd9,   16'd999,   16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'h2000, 16'h2000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd9,   8'd11,  16'hFFFF,  16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd11,  8'd9,   16'd1,     16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'hE000, 16'h2000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'd4801, 16'd11583, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'd11583, 16'd4801, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'h0000, 16'h0000, 1'b1, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'h8000, 16'h8000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd10,  8'd10,  16'h0000,  16'h7FFF, 16'h8000, 1'b0, Rejected},
    '{CMD_LOAD,  8'd20,  8'd20,  16'd0,     16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd20,  8'd20,  16'h0000,  16'd100,  16'h0000, 1'b1, Rejected},
    '{CMD_LOAD,  8'd255, 8'd255, 16'hFFFF,  16'hFFFF, 16'hFFFF, 1'b0, Rejected},
    '{CMD_QUERY, 8'd255, 8'd255, 16'hFFFF,  16'h7FFF, 16'h7FFF, 1'b1, Rejected},
    '{CMD_LOAD,  8'd1,   8'd1,   16'hFFFF,  16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd1,   8'd1,   16'h0000,  16'h0000, 16'h4000, 1'b1, Rejected},
    '{CMD_LOAD,  8'd0,   8'd0,   16'd0,     16'h0000, 16'h0000, 1'b0, Rejected},
    '{CMD_QUERY, 8'd254, 8'd128, 16'h0000,  16'h4000, 16'h0000, 1'b1, Rejected}
  };

  localparam logic [8:0] PhaseWidth  [PhaseCount] = '{9'd40, 9'd3, 9'd511, 9'd24,
                                                      9'd12, 9'd256, 9'd30, 9'd300};
  localparam logic [8:0] PhaseHeight [PhaseCount] = '{9'd40, 9'd3, 9'd511, 9'd17,
                                                      9'd12, 9'd256, 9'd9, 9'd260};
  localparam logic [3:0] PhaseHalf   [PhaseCount] = '{4'd1, 4'd0, 4'd15, 4'd2,
                                                      4'd0, 4'd8, 4'd3, 4'd9};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i;
  logic [8:0]  cfg_data_i;

  logic [15:0] pix_mem [0:65535];
  bit          pix_written [0:65535];
  logic [8:0]  cfg_fw;
  logic [8:0]  cfg_fh;
  logic [3:0]  cfg_hw;

  thin_res_t   pending_thin_q [$];
  thin_res_t   head_res;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          beats_sent;
  int          results_seen;
  int          mismatch_count;
  int          cycle_count;

  gradient_edge_thinning dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int half_sat();
    return (cfg_hw > MaxHalfWidth) ? MaxHalfWidth : int'(cfg_hw);
  endfunction

  function automatic logic [1:0] dominant_axis(input logic signed [15:0] gx,
                                               input logic signed [15:0] gy);
    longint dx, dy, pn, pe, pd, pa, top;
    dx = gx;
    dy = gy;
    pn = ((dy < 0) ? -dy : dy) * AxisScale;
    pe = ((dx < 0) ? -dx : dx) * AxisScale;
    pd = ((dx + dy < 0) ? -(dx + dy) : (dx + dy)) * DiagNum;
    pa = ((dy - dx < 0) ? -(dy - dx) : (dy - dx)) * DiagNum;
    top = pn;
    if (pe > top) top = pe;
    if (pd > top) top = pd;
    if (pa > top) top = pa;
    if (pn == top) return AXIS_VERT;
    if (pe == top) return AXIS_HORZ;
    if (pd == top) return AXIS_DIAG;
    return AXIS_ANTI;
  endfunction

  function automatic void axis_step(input logic [1:0] axis, output int ax, output int ay);
    case (axis)
      AXIS_VERT: begin ax = 0;  ay = 1; end
      AXIS_HORZ: begin ax = 1;  ay = 0; end
      AXIS_DIAG: begin ax = 1;  ay = 1; end
      default:   begin ax = -1; ay = 1; end
    endcase
  endfunction

  function automatic thin_res_t predict_thin(input logic [7:0] c, input logic [7:0] r,
                                             input logic [15:0] gx, input logic [15:0] gy);
    int w, h, sc, x, y, ax, ay, s;
    logic [15:0] p;
    thin_res_t res;
    res = Rejected;
    w = (cfg_fw > FrameCap) ? FrameCap : int'(cfg_fw);
    h = (cfg_fh > FrameCap) ? FrameCap : int'(cfg_fh);
    sc = half_sat();
    x = c;
    y = r;
    if (x - sc <= 0 || x + sc >= w - 1 || y - sc <= 0 || y + sc >= h - 1) return res;
    if (gx == 16'd0 && gy == 16'd0) return res;
    axis_step(dominant_axis(gx, gy), ax, ay);
    p = pix_mem[{r, c}];
    if (p == 16'd0) return res;
    for (s = 1; s <= sc; s++) begin
      if (pix_mem[(y + ay * s) * FrameCap + x + ax * s] >= p) return res;
      if (pix_mem[(y - ay * s) * FrameCap + x - ax * s] >= p) return res;
    end
    res.kept = 1'b1;
    res.value = p;
    return res;
  endfunction

  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hC000;
      5: return 16'd11583;
      6: return 16'd4801;
      7: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch on result %0d, %s: want %0h got %0h (cycle %0d)",
             results_seen, what, want, got, cycle_count);
    mismatch_count++;
  endtask

  task automatic send_beat(input logic cmd, input logic [7:0] c, input logic [7:0] r,
                           input logic [15:0] pv, input logic [15:0] gx,
                           input logic [15:0] gy, input logic use_typed = 1'b0,
                           input thin_res_t typed_res = '0);
    thin_res_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gy, gx, pv, r, c};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (cmd == CMD_LOAD) begin
      pix_mem[{r, c}] = pv;
      pix_written[{r, c}] = 1'b1;
    end else begin
      res = predict_thin(c, r, gx, gy);
      if (use_typed) res = typed_res;
      pending_thin_q = {pending_thin_q, res};
    end
  endtask

  // loads every pixel of the query window along its axis that was never written
  task automatic prime_window(input logic [7:0] c, input logic [7:0] r,
                              input logic [15:0] gx, input logic [15:0] gy);
    int sc, ax, ay, s, k, x, y;
    sc = half_sat();
    axis_step(dominant_axis(gx, gy), ax, ay);
    for (s = 0; s <= sc; s++) begin
      for (k = -1; k <= 1; k += 2) begin
        x = int'(c) + k * ax * s;
        y = int'(r) + k * ay * s;
        if (x >= 0 && x < FrameCap && y >= 0 && y < FrameCap && !pix_written[y * FrameCap + x])
          send_beat(CMD_LOAD, 8'(x), 8'(y), 16'($urandom), 16'h0000, 16'h0000);
      end
    end
  endtask

  // center plus mostly lower neighbors along the axis, then the query
  task automatic drive_peak(input logic [7:0] c, input logic [7:0] r,
                            input logic [15:0] gx, input logic [15:0] gy);
    int sc, ax, ay, s, k, x, y;
    logic [15:0] top, nb;
    sc = half_sat();
    axis_step(dominant_axis(gx, gy), ax, ay);
    top = 16'($urandom_range(1, 65535));
    send_beat(CMD_LOAD, c, r, top, 16'($urandom), 16'($urandom));
    for (s = 1; s <= sc; s++) begin
      for (k = -1; k <= 1; k += 2) begin
        x = int'(c) + k * ax * s;
        y = int'(r) + k * ay * s;
        if (x >= 0 && x < FrameCap && y >= 0 && y < FrameCap) begin
          nb = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(0, int'(top) - 1));
          send_beat(CMD_LOAD, 8'(x), 8'(y), nb, 16'h0000, 16'h0000);
        end
      end
    end
    send_beat(CMD_QUERY, c, r, 16'($urandom), gx, gy);
  endtask

  task automatic apply_frame_cfg(input logic [8:0] fw, input logic [8:0] fh,
                                 input logic [3:0] hw);
    logic [1:0] regs [3];
    logic [8:0] vals [3];
    int i;
    regs = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_HALF_WIDTH};
    vals = '{fw, fh, {5'd0, hw}};
    for (i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[i])
        REG_FRAME_WIDTH:  cfg_fw = vals[i];
        REG_FRAME_HEIGHT: cfg_fh = vals[i];
        default:          cfg_hw = vals[i][3:0];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_thin_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_thin_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 32'({m_axis_tuser, m_axis_tdata}));
        end else begin
          head_res = pending_thin_q.pop_front();
          if (m_axis_tuser[0] !== head_res.kept)
            report_mismatch("kept", 32'(head_res.kept), 32'(m_axis_tuser[0]));
          if (m_axis_tdata !== head_res.value)
            report_mismatch("thinned_value", 32'(head_res.value), 32'(m_axis_tdata));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int ph, start, pick, col_lim, row_lim, i;
    logic [7:0] c, r;
    logic [15:0] gx, gy;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_valid_i    = 1'b0;
    cfg_addr_i     = '0;
    cfg_data_i     = '0;
    cfg_fw         = 9'd256;
    cfg_fh         = 9'd256;
    cfg_hw         = 4'd1;
    tx_idle_pct    = 36;
    rx_idle_pct    = 52;
    beats_sent     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirCount; i++) begin
      if (DirRows[i].cmd == CMD_QUERY)
        prime_window(DirRows[i].col, DirRows[i].row, DirRows[i].gx, DirRows[i].gy);
      send_beat(DirRows[i].cmd, DirRows[i].col, DirRows[i].row, DirRows[i].pix,
                DirRows[i].gx, DirRows[i].gy, DirRows[i].typed, DirRows[i].res);
    end
    drain_results();

    for (ph = 0; ph < PhaseCount; ph++) begin
      tx_idle_pct = (ph < 3) ? 36 : (ph < 6) ? 52 : 0;
      rx_idle_pct = (ph < 3) ? 52 : (ph < 6) ? 36 : 0;
      apply_frame_cfg(PhaseWidth[ph], PhaseHeight[ph], PhaseHalf[ph]);
      col_lim = ((cfg_fw > FrameCap) ? FrameCap : int'(cfg_fw)) + 1;
      row_lim = ((cfg_fh > FrameCap) ? FrameCap : int'(cfg_fh)) + 1;
      if (col_lim > FrameCap - 1) col_lim = FrameCap - 1;
      if (row_lim > FrameCap - 1) row_lim = FrameCap - 1;
      start = beats_sent;
      while (beats_sent - start < PhaseBeats) begin
        c = 8'($urandom_range(0, col_lim));
        r = 8'($urandom_range(0, row_lim));
        gx = rand_grad();
        gy = rand_grad();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          drive_peak(c, r, gx, gy);
        end else if (pick < 75) begin
          prime_window(c, r, gx, gy);
          send_beat(CMD_QUERY, c, r, 16'($urandom), gx, gy);
        end else if (pick < 90) begin
          send_beat(CMD_LOAD, c, r, 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          c = 8'($urandom);
          r = 8'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            send_beat(CMD_LOAD, c, r, 16'($urandom), gx, gy);
          end else begin
            prime_window(c, r, gx, gy);
            send_beat(CMD_QUERY, c, r, 16'($urandom), gx, gy);
          end
        end
      end
      drain_results();
    end

    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
